### rtl/rxrfc_pkg.sv
package rxrfc_pkg;

   // Operation codes carried on req_opcode.
   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_POLL  = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   // The frame header sits this many bytes past the consumer pointer.
   localparam int unsigned HDR_OFFSET = 16;
   // Bytes of header, and bytes of CRC at the end of each frame.
   localparam int unsigned HDR_BYTES = 4;
   localparam int unsigned CRC_BYTES = 4;
   // Bit of the status half-word that marks a complete frame.
   localparam int unsigned STATUS_OK_BIT = 0;

   // Configuration port: address width and register indexes.
   localparam int unsigned CSR_AW = 3;
   localparam logic CSR_IDX_RX_ENABLE = 1'b0;

   // Outcome of checking one frame header.
   typedef struct packed {
      logic        ok;
      logic [14:0] start;
      logic [14:0] length;
      logic [15:0] next_cp;
   } poll_res_type;

endpackage

### rtl/rxrfc_ram.sv
module rxrfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/rxrfc_poll.sv
module rxrfc_poll #(
   parameter int RING_BYTES = 32768
) (
   input  logic                  rx_enable,
   input  logic [15:0]           cp,
   input  logic [31:0]           header,
   input  logic [15:0]           producer_ptr,
   input  logic [15:0]           dest_capacity,
   output rxrfc_pkg::poll_res_type res
);
   import rxrfc_pkg::*;

   localparam int AW = $clog2(RING_BYTES);

   logic [16:0]   cp_plus;
   logic [AW-1:0] off;
   logic [15:0]   status;
   logic [15:0]   len;
   logic          len_ok;
   logic [AW-1:0] unread;
   logic [17:0]   want_sum;
   logic [17:0]   want;
   logic          span_ok;
   logic [17:0]   next_sum;
   logic [17:0]   next_aligned;
   logic [AW-1:0] next_off;
   logic [AW-1:0] start_off;
   logic [15:0]   copy;
   logic [15:0]   copy_capped;

   // The header word lies at the consumer pointer plus the header offset.
   assign cp_plus = {1'b0, cp} + 17'(HDR_OFFSET);
   assign off     = cp_plus[AW-1:0];
   assign status  = header[15:0];
   assign len     = header[31:16];

   // The length must cover the CRC and leave room in the ring.
   assign len_ok = (len >= 16'(CRC_BYTES)) &&
                   ({1'b0, len} <= 17'(RING_BYTES - CRC_BYTES));

   // The producer must be far enough ahead to hold the aligned frame.
   assign unread   = producer_ptr[AW-1:0] - off;
   assign want_sum = 18'(len) + 18'(HDR_BYTES + 3);
   assign want     = want_sum & ~18'd3;
   assign span_ok  = (unread != '0) && (18'(unread) >= want);

   // Next frame starts past this one, rounded up to a word.
   assign next_sum     = 18'(off) + 18'(len) + 18'(HDR_BYTES + 3);
   assign next_aligned = next_sum & ~18'd3;
   assign next_off     = next_aligned[AW-1:0];

   // Data begins right after the header; the copy drops the CRC.
   assign start_off   = off + AW'(HDR_BYTES);
   assign copy        = len - 16'(CRC_BYTES);
   assign copy_capped = (copy > dest_capacity) ? dest_capacity : copy;

   assign res.ok      = rx_enable && status[STATUS_OK_BIT] && len_ok && span_ok;
   assign res.start   = 15'(start_off);
   assign res.length  = 15'(copy_capped);
   assign res.next_cp = 16'(next_off) - 16'(HDR_OFFSET);

endmodule

### rtl/rx_ring_frame_consumer_top.sv
// Receive ring consumer.
// Commands enter on start with the req_ ports and are taken when busy is low.
// Opcode store writes one byte into the ring, read returns one byte on
// rsp_read_data, and poll checks the frame header at the consumer pointer
// plus 16. A good frame is reported on rsp_frame_ready, rsp_frame_start and
// rsp_frame_length, its header is zeroed and the pointer moves past it.
// Every command gives exactly one result word, shown for one cycle with
// rsp_valid; the receiver must take it then.
// The command is registered and its ring read issued at the accepting edge;
// it executes in ST_EXEC and its result word is registered as it leaves.
// A new command is taken only once the last has executed: the ring is a
// 32-bit-wide memory with registered read data, and each command does one
// read and at most one write-back (byte merge or header clear).
// rx_enable is written through the APB port at byte address 0.
// After reset the block is busy while it zeroes the ring, one word per cycle;
// configuration writes are taken during that pass.
// RING_BYTES must be a power of two.
module rx_ring_frame_consumer_top #(
   parameter int RING_BYTES = 32768
) (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [14:0]                   req_ring_addr,
   input  logic [7:0]                    req_write_byte,
   input  logic [15:0]                   req_producer_ptr,
   input  logic [15:0]                   req_dest_capacity,
   // Result channel
   output logic                          rsp_valid,
   output logic                          rsp_frame_ready,
   output logic [14:0]                   rsp_frame_start,
   output logic [14:0]                   rsp_frame_length,
   output logic [15:0]                   rsp_consumer_ptr,
   output logic [7:0]                    rsp_read_data,
   output logic [31:0]                   rsp_frames_received,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rxrfc_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import rxrfc_pkg::*;

   localparam int AW    = $clog2(RING_BYTES);
   localparam int WW    = AW - 2;
   localparam int WORDS = RING_BYTES / 4;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type    state_ff;
   logic [WW-1:0] clr_idx_ff;
   opcode_type   op_ff;
   logic [AW-1:0] addr_ff;
   logic [7:0]   wbyte_ff;
   logic [15:0]  prod_ff;
   logic [15:0]  cap_ff;
   logic [15:0]  cp_ff;
   logic [15:0]  cp_in;
   logic [31:0]  count_ff;
   logic [31:0]  count_in;
   logic         en_ff;

   logic         rsp_valid_ff;
   logic         rsp_frame_ready_ff;
   logic [14:0]  rsp_frame_start_ff;
   logic [14:0]  rsp_frame_length_ff;
   logic [15:0]  rsp_consumer_ptr_ff;
   logic [7:0]   rsp_read_data_ff;
   logic [31:0]  rsp_frames_received_ff;

   logic [15:0]  req_addr_ext;
   logic [WW-1:0] req_word;
   logic [16:0]  cp_plus;
   logic [WW-1:0] off_word;
   logic         accept;
   logic         frame_taken;
   logic [1:0]   lane;
   logic [7:0]   rd_byte;
   logic [31:0]  merged;

   logic          ram_we;
   logic [WW-1:0] ram_waddr;
   logic [31:0]   ram_wdata;
   logic [WW-1:0] ram_raddr;
   logic [31:0]   ram_rdata;

   poll_res_type poll;

   // Word index of the current frame header.
   assign cp_plus  = {1'b0, cp_ff} + 17'(HDR_OFFSET);
   assign off_word = cp_plus[AW-1:2];

   assign req_addr_ext = 16'(req_ring_addr);
   assign req_word     = req_addr_ext[AW-1:2];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The read is issued at the accepting edge so data is back in ST_EXEC.
   assign ram_raddr = (req_opcode == OP_POLL) ? off_word : req_word;

   rxrfc_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rxrfc_poll #(
      .RING_BYTES (RING_BYTES)
   ) u_poll (
      .rx_enable     (en_ff),
      .cp            (cp_ff),
      .header        (ram_rdata),
      .producer_ptr  (prod_ff),
      .dest_capacity (cap_ff),
      .res           (poll)
   );

   // Byte lane selection for store and read.
   assign lane    = addr_ff[1:0];
   assign rd_byte = ram_rdata[8*lane +: 8];

   always_comb begin
      merged = ram_rdata;
      merged[8*lane +: 8] = wbyte_ff;
   end

   assign frame_taken = (state_ff == ST_EXEC) && (op_ff == OP_POLL) && poll.ok;

   // Pointer and frame count after this command.
   assign cp_in    = frame_taken ? poll.next_cp : cp_ff;
   assign count_in = frame_taken ? (count_ff + 32'd1) : count_ff;

   // Write-back: zero sweep after reset, byte merge, or header clear.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff[AW-1:2];
      ram_wdata = merged;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_ff;
            ram_wdata = '0;
         end
         ST_EXEC: begin
            if (op_ff == OP_STORE) begin
               ram_we = 1'b1;
            end else if (frame_taken) begin
               ram_we    = 1'b1;
               ram_waddr = off_word;
               ram_wdata = '0;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Sequencer, architectural state and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         cp_ff        <= 16'(RING_BYTES - HDR_OFFSET);
         count_ff     <= '0;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (psel && penable && pwrite &&
             (paddr[CSR_AW-1:2] == CSR_IDX_RX_ENABLE)) begin
            en_ff <= pwdata[0];
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + WW'(1);
               if (clr_idx_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= opcode_type'(req_opcode);
                  addr_ff  <= req_addr_ext[AW-1:0];
                  wbyte_ff <= req_write_byte;
                  prod_ff  <= req_producer_ptr;
                  cap_ff   <= req_dest_capacity;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               cp_ff                  <= cp_in;
               count_ff               <= count_in;
               rsp_valid_ff           <= 1'b1;
               rsp_frame_ready_ff     <= frame_taken;
               rsp_frame_start_ff     <= frame_taken ? poll.start : '0;
               rsp_frame_length_ff    <= frame_taken ? poll.length : '0;
               rsp_consumer_ptr_ff    <= cp_in;
               rsp_read_data_ff       <= (op_ff == OP_READ) ? rd_byte : '0;
               rsp_frames_received_ff <= count_in;
               state_ff               <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ready     = rsp_frame_ready_ff;
   assign rsp_frame_start     = rsp_frame_start_ff;
   assign rsp_frame_length    = rsp_frame_length_ff;
   assign rsp_consumer_ptr    = rsp_consumer_ptr_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_frames_received = rsp_frames_received_ff;

   // Register read-back.
   assign prdata = (paddr[CSR_AW-1:2] == CSR_IDX_RX_ENABLE) ? {31'd0, en_ff} : 32'd0;
   assign pready = 1'b1;

   // A result word only follows an execute cycle.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an executed command");

   // A reported frame bumps the frame count by exactly one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_ready_ff) |-> (count_ff == $past(count_ff) + 32'd1))
      else $error("frame count did not advance with a reported frame");

   // The consumer pointer always stays word aligned.
   a_cp_aligned: assert property (@(posedge clock) disable iff (reset)
      cp_ff[1:0] == 2'b00)
      else $error("consumer pointer lost word alignment");

   // The ring is never written while waiting for a command.
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("ring write while idle");

endmodule

### verif/rx_ring_frame_consumer_top_tb.sv
`timescale 1ns / 1ps

module rx_ring_frame_consumer_top_tb;

   import rxrfc_pkg::*;

   localparam int unsigned RING = 32768;
   localparam int unsigned ITEM_TARGET = 1200;
   localparam int unsigned PHASE_ITEMS = 150;
   localparam int unsigned QUIET_TAIL = 200;
   localparam int unsigned IDLE_SETTLE = 8;
   localparam int unsigned N_DIRECTED = 31;

   // Opcode 3 has no meaning in the block and must leave the state alone.
   localparam logic [1:0] OP_NOP = 2'd3;

   // Byte addresses on the configuration port.
   localparam logic [14:0] RX_EN_ADDR = 15'(4 * CSR_IDX_RX_ENABLE);
   localparam logic [14:0] SPARE_ADDR = RX_EN_ADDR + 15'd4;

   // One result word as the block shows it on the rsp_ ports.
   typedef struct packed {
      logic        ready;
      logic [14:0] first;
      logic [14:0] length;
      logic [15:0] cptr;
      logic [7:0]  rdata;
      logic [31:0] count;
   } rsp_word_type;

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_type;

   // A row is either a command word or a register write (addr and wbyte
   // then hold the register address and its value).
   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   opcode;
      logic [14:0]  addr;
      logic [7:0]   wbyte;
      logic [15:0]  prod;
      logic [15:0]  cap;
      logic         typed;
      rsp_word_type fixed_word;
   } stim_row_type;

   localparam rsp_word_type NO_WORD = '0;
   localparam rsp_word_type AT_RESET = '{ready: 1'b0, first: 15'd0, length: 15'd0,
                                         cptr: 16'(RING - HDR_OFFSET), rdata: 8'd0,
                                         count: 32'd0};

   // Directed walk. The first frame header sits at offset 0 after reset.
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // Receive path off, and the state right after reset.
      '{ROW_CSR, OP_STORE, RX_EN_ADDR, 8'h00, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_READ, 15'd0, 8'h00, 16'd0, 16'd0, 1'b1, AT_RESET},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd100, 16'd100, 1'b1, AT_RESET},
      '{ROW_CMD, OP_STORE, 15'd0, 8'h01, 16'd0, 16'd0, 1'b1, AT_RESET},
      '{ROW_CMD, OP_STORE, 15'd2, 8'h40, 16'd0, 16'd0, 1'b1, AT_RESET},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd200, 16'd100, 1'b1, AT_RESET},
      // Enable the path; a write to an unused address changes nothing.
      '{ROW_CSR, OP_STORE, RX_EN_ADDR, 8'h01, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CSR, OP_STORE, SPARE_ADDR, 8'h00, 16'd0, 16'd0, 1'b0, NO_WORD},
      // Nothing unread, then the exact span of a 64-byte frame.
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd0, 16'd100, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd68, 16'hFFFF, 1'b0, NO_WORD},
      '{ROW_CMD, OP_READ, 15'd0, 8'h00, 16'd0, 16'd0, 1'b0, NO_WORD},
      // Header at 68: status bit clear, then a length below the CRC size.
      '{ROW_CMD, OP_STORE, 15'd68, 8'hFE, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd70, 8'h10, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'hFFFF, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd68, 8'h03, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd70, 8'h03, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd1000, 16'd100, 1'b0, NO_WORD},
      // Shortest frame, nothing left after the CRC.
      '{ROW_CMD, OP_STORE, 15'd70, 8'h04, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd76, 16'd0, 1'b0, NO_WORD},
      // Header at 76: longest legal length never fits the unread span.
      '{ROW_CMD, OP_STORE, 15'd76, 8'hFF, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd78, 8'hFC, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd79, 8'h7F, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd75, 16'hFFFF, 1'b0, NO_WORD},
      // A long frame, one byte short and then exact; next header at 32760.
      '{ROW_CMD, OP_STORE, 15'd78, 8'hA8, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd32759, 16'hFFFF, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd32760, 16'hFFFF, 1'b0, NO_WORD},
      // Frame data runs across the ring end; the copy length is capped.
      '{ROW_CMD, OP_STORE, 15'd32760, 8'h01, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_STORE, 15'd32762, 8'h40, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_POLL, 15'd0, 8'h00, 16'd32828, 16'd10, 1'b0, NO_WORD},
      '{ROW_CMD, OP_READ, 15'd32767, 8'h00, 16'd0, 16'd0, 1'b0, NO_WORD},
      '{ROW_CMD, OP_NOP, 15'h7FFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_WORD}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [14:0] req_ring_addr = '0;
   logic [7:0]  req_write_byte = '0;
   logic [15:0] req_producer_ptr = '0;
   logic [15:0] req_dest_capacity = '0;
   logic        rsp_valid;
   logic        rsp_frame_ready;
   logic [14:0] rsp_frame_start;
   logic [14:0] rsp_frame_length;
   logic [15:0] rsp_consumer_ptr;
   logic [7:0]  rsp_read_data;
   logic [31:0] rsp_frames_received;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Local copy of the ring, the pointer, the frame count and the enable.
   logic [7:0]  ring_copy [RING];
   logic [15:0] cons_ptr_m;
   logic [31:0] frame_cnt_m;
   logic        rx_en_m;

   rsp_word_type rsp_words_due [$];
   int unsigned  mismatch_count = 0;
   int unsigned  items_sent = 0;
   bit           gaps_on = 1'b0;

   rx_ring_frame_consumer_top #(
      .RING_BYTES(RING)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_ring_addr(req_ring_addr),
      .req_write_byte(req_write_byte),
      .req_producer_ptr(req_producer_ptr),
      .req_dest_capacity(req_dest_capacity),
      .rsp_valid(rsp_valid),
      .rsp_frame_ready(rsp_frame_ready),
      .rsp_frame_start(rsp_frame_start),
      .rsp_frame_length(rsp_frame_length),
      .rsp_consumer_ptr(rsp_consumer_ptr),
      .rsp_read_data(rsp_read_data),
      .rsp_frames_received(rsp_frames_received),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit, far above the slowest legal run including the clearing pass.
   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end

   // Applies one command word to the local ring and returns its result word.
   function automatic rsp_word_type apply_command(logic [1:0] op, logic [14:0] addr,
                                                  logic [7:0] wb, logic [15:0] prod,
                                                  logic [15:0] cap);
      rsp_word_type w;
      int unsigned  off;
      int unsigned  unread;
      int unsigned  want;
      int unsigned  copy;
      int unsigned  nxt;
      logic [15:0]  status;
      logic [15:0]  flen;
      w = '0;
      case (op)
         OP_STORE: ring_copy[32'(addr) % RING] = wb;
         OP_READ: w.rdata = ring_copy[32'(addr) % RING];
         OP_POLL: begin
            if (rx_en_m) begin
               off = (32'(cons_ptr_m) + HDR_OFFSET) % RING;
               status = {ring_copy[(off + 1) % RING], ring_copy[off]};
               flen = {ring_copy[(off + 3) % RING], ring_copy[(off + 2) % RING]};
               unread = (RING + 32'(prod) - off) % RING;
               want = (32'(flen) + CRC_BYTES + 3) & ~32'd3;
               if (status[STATUS_OK_BIT] && flen >= CRC_BYTES &&
                   32'(flen) <= RING - CRC_BYTES && unread != 0 && unread >= want) begin
                  copy = 32'(flen) - CRC_BYTES;
                  if (copy > 32'(cap)) copy = 32'(cap);
                  w.ready = 1'b1;
                  w.first = 15'((off + HDR_BYTES) % RING);
                  w.length = 15'(copy);
                  nxt = ((off + 32'(flen) + CRC_BYTES + 3) & ~32'd3) % RING;
                  cons_ptr_m = 16'(nxt - HDR_OFFSET);
                  for (int k = 0; k < HDR_BYTES; k++) ring_copy[(off + k) % RING] = '0;
                  frame_cnt_m = frame_cnt_m + 32'd1;
               end
            end
         end
         default: ;
      endcase
      w.cptr = cons_ptr_m;
      w.count = frame_cnt_m;
      return w;
   endfunction

   // Holds one command word on the req_ ports until the block takes it.
   task automatic drive_command(logic [1:0] op, logic [14:0] addr, logic [7:0] wb,
                                logic [15:0] prod, logic [15:0] cap, logic typed,
                                rsp_word_type fixed_word);
      rsp_word_type w;
      start <= 1'b1;
      req_opcode <= op;
      req_ring_addr <= addr;
      req_write_byte <= wb;
      req_producer_ptr <= prod;
      req_dest_capacity <= cap;
      do @(posedge clock); while (busy !== 1'b0);
      w = apply_command(op, addr, wb, prod, cap);
      rsp_words_due.push_back(typed ? fixed_word : w);
   endtask

   task automatic idle_gap(int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Random-part command, with an occasional idle burst in front of it.
   task automatic issue_command(logic [1:0] op, int unsigned addr, int unsigned wb,
                                int unsigned prod, int unsigned cap);
      if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
      drive_command(op, 15'(addr % RING), 8'(wb), 16'(prod), 16'(cap), 1'b0, NO_WORD);
      if (op != OP_NOP) items_sent++;
   endtask

   // Lets every outstanding result word drain before a register write.
   task automatic wait_idle();
      start <= 1'b0;
      while (rsp_words_due.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [14:0] addr, logic [31:0] data,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr[CSR_AW-1:0];
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Register write; the enable is read back to confirm it took.
   task automatic write_csr(logic [14:0] addr, logic [31:0] data);
      logic [31:0] rd;
      csr_access(1'b1, addr, data, rd);
      if (addr == RX_EN_ADDR) begin
         rx_en_m = data[0];
         csr_access(1'b0, addr, 32'd0, rd);
         if (rd[0] !== data[0]) begin
            $display("%0t rx_enable readback: expected %0h, got %0h", $time, data[0], rd[0]);
            mismatch_count++;
         end
      end
   endtask

   task automatic report_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t %s: expected %0h, got %0h", $time, fname, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Each result word is compared with the oldest word still due.
   always @(posedge clock) begin : rsp_check
      rsp_word_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (rsp_words_due.size() == 0) begin
            $display("%0t result word with none due", $time);
            mismatch_count++;
         end else begin
            due = rsp_words_due.pop_front();
            report_field("rsp_frame_ready", 32'(due.ready), 32'(rsp_frame_ready));
            report_field("rsp_frame_start", 32'(due.first), 32'(rsp_frame_start));
            report_field("rsp_frame_length", 32'(due.length), 32'(rsp_frame_length));
            report_field("rsp_consumer_ptr", 32'(due.cptr), 32'(rsp_consumer_ptr));
            report_field("rsp_read_data", 32'(due.rdata), 32'(rsp_read_data));
            report_field("rsp_frames_received", due.count, rsp_frames_received);
         end
      end
   end

   initial begin : stimulus
      int unsigned  off;
      int unsigned  flen;
      int unsigned  want;
      int unsigned  unread;
      int unsigned  prod;
      int unsigned  cap;
      int unsigned  pick;
      int unsigned  phase_no;
      int unsigned  next_phase_at;
      bit           phase_gaps;
      logic [15:0]  status;
      stim_row_type row;

      for (int i = 0; i < RING; i++) ring_copy[i] = '0;
      cons_ptr_m = 16'(RING - HDR_OFFSET);
      frame_cnt_m = '0;
      rx_en_m = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table first.
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.addr, 32'(row.wbyte));
         end else begin
            drive_command(row.opcode, row.addr, row.wbyte, row.prod, row.cap,
                          row.typed, row.fixed_word);
         end
      end

      // Random part: mostly complete frames at the current header offset.
      phase_no = 0;
      next_phase_at = 0;
      phase_gaps = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_phase_at) begin
            wait_idle();
            if (phase_no == 2) write_csr(RX_EN_ADDR, 32'd0);
            else if (phase_no == 0) write_csr(RX_EN_ADDR, 32'd1);
            else write_csr(RX_EN_ADDR, 32'($urandom_range(0, 4) != 0));
            phase_gaps = ($urandom_range(0, 2) != 0);
            phase_no++;
            next_phase_at = items_sent + PHASE_ITEMS;
         end
         gaps_on = phase_gaps && (items_sent + QUIET_TAIL < ITEM_TARGET);

         off = (32'(cons_ptr_m) + HDR_OFFSET) % RING;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // Well-formed header, some data, a poll, then a few reads.
            if ($urandom_range(0, 15) == 0) flen = $urandom_range(81, RING - CRC_BYTES);
            else flen = $urandom_range(4, 80);
            status = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) != 0) status[STATUS_OK_BIT] = 1'b1;
            issue_command(OP_STORE, off, status[7:0], $urandom, $urandom);
            issue_command(OP_STORE, off + 1, status[15:8], $urandom, $urandom);
            issue_command(OP_STORE, off + 2, flen & 32'hFF, $urandom, $urandom);
            issue_command(OP_STORE, off + 3, flen >> 8, $urandom, $urandom);
            repeat ($urandom_range(0, 3))
               issue_command(OP_STORE, off + HDR_BYTES + $urandom_range(0, flen - 1),
                             $urandom_range(0, 255), $urandom, $urandom);
            want = (flen + CRC_BYTES + 3) & ~32'd3;
            case ($urandom_range(0, 9))
               0: unread = 0;
               1: unread = want - 1;
               2: unread = $urandom_range(0, RING - 1);
               default: unread = want + $urandom_range(0, 40);
            endcase
            if (unread >= RING) unread = RING - 1;
            prod = (off + unread) % RING + ($urandom_range(0, 1) != 0 ? RING : 0);
            case ($urandom_range(0, 4))
               0: cap = 0;
               1: cap = 32'hFFFF;
               2: cap = $urandom_range(0, 65535);
               default: cap = $urandom_range(0, flen);
            endcase
            issue_command(OP_POLL, $urandom, $urandom, prod, cap);
            repeat ($urandom_range(0, 2))
               issue_command(OP_READ, off + $urandom_range(0, flen + 3), $urandom,
                             $urandom, $urandom);
         end else if (pick < 85) begin
            // Broken header: bad status, too short, or far too long.
            case ($urandom_range(0, 2))
               0: issue_command(OP_STORE, off, $urandom_range(0, 255) & 32'hFE,
                                $urandom, $urandom);
               1: begin
                  issue_command(OP_STORE, off + 2, $urandom_range(0, 3), $urandom, $urandom);
                  issue_command(OP_STORE, off + 3, 0, $urandom, $urandom);
               end
               default: issue_command(OP_STORE, off + 3, $urandom_range(128, 255),
                                      $urandom, $urandom);
            endcase
            issue_command(OP_POLL, $urandom, $urandom,
                          (off + $urandom_range(1, RING - 1)) % RING, $urandom);
         end else begin
            // Noise over the whole field ranges, opcode 3 included.
            issue_command(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
